[hdl/gcbp_pkg.sv]
// Shared types, codes and helpers of the glyph column to panel byte packer.
`default_nettype none

package gcbp_pkg;

  // Transpose buffer geometry
  localparam int unsigned BUF_BYTES = 32;
  localparam int unsigned BUF_IDX_W = $clog2(BUF_BYTES);

  // Top buffer index sent on a flush, single and double size
  localparam logic [BUF_IDX_W-1:0] TOP_SINGLE = BUF_IDX_W'(15);
  localparam logic [BUF_IDX_W-1:0] TOP_DOUBLE = BUF_IDX_W'(BUF_BYTES - 1);

  // Aligned words before the carry word is sent
  localparam logic [2:0] LIMIT_SINGLE = 3'd2;
  localparam logic [2:0] LIMIT_DOUBLE = 3'd4;

  // Input commands
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_COLUMN = 2'd1,
    CMD_END    = 2'd2
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DIRECTION_Y = 2'd0,
    REG_DOUBLE_SIZE = 2'd1,
    REG_START_PHASE = 2'd2
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_Y_BYTE,
    ST_Y_CARRY,
    ST_X_SEND
  } state_e;

  // Input word
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       column_flush;
  } out_word_t;

  // Aligner controls
  typedef struct packed {
    logic       clear;
    logic       step;
    logic       take_carry;
    logic [2:0] shift;
    logic       dbl;
    logic [7:0] data;
  } aln_ctl_t;

  // Aligner status
  typedef struct packed {
    logic [7:0] aligned;
    logic [7:0] carry;
    logic       due;
  } aln_sts_t;

  // Transpose buffer controls
  typedef struct packed {
    logic       clear;
    logic       merge;
    logic       dbl;
    logic [2:0] phase;
    logic [7:0] lo;
    logic [7:0] hi;
  } buf_ctl_t;

  // Widen a nibble: every bit becomes two bits
  function automatic logic [7:0] widen_nibble(input logic [3:0] nib);
    logic [7:0] w;
    for (int k = 0; k < 4; k++) begin
      w[2*k]   = nib[k];
      w[2*k+1] = nib[k];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

[hdl/glyph_column_to_panel_byte_packer.sv]
// Glyph column to panel byte packer: top level.
//
// Accepts one command word at a time (start, glyph column, end) and sends panel
// frame-buffer bytes, one output word per cycle while the output is not stalled.
// The input is stalled from the cycle after an item is taken until its last byte
// is in the output register; that byte may still wait there while the next item
// is taken. Start, end with nothing to send, unused commands and X columns that
// do not complete a byte column send no bytes and leave the input free. A Y
// column sends 2 or 3 bytes single size, 8 to 10 bytes double size, through the
// single bit aligner that shifts one byte per cycle while the output is not
// stalled. An X flush sends 15 (single) or 31 (double) bytes through the single
// read port of the transpose buffer. Configuration writes are always ready and
// apply to the next item; write them only while no bytes are pending.
`default_nettype none

module glyph_column_to_panel_byte_packer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [7:0]          cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire gcbp_pkg::in_word_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output gcbp_pkg::out_word_t      out_data_o
);

  gcbp_pkg::aln_ctl_t aln_ctl;
  gcbp_pkg::aln_sts_t aln_sts;
  gcbp_pkg::buf_ctl_t buf_ctl;
  logic [gcbp_pkg::BUF_IDX_W-1:0] rd_idx;
  logic [7:0] rd_data;

  assign cfg_ready_o = 1'b1;

  gcbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .aln_ctl_o   (aln_ctl),
    .aln_sts_i   (aln_sts),
    .buf_ctl_o   (buf_ctl),
    .rd_idx_o    (rd_idx),
    .rd_data_i   (rd_data)
  );

  gcbp_aligner u_aligner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (aln_ctl),
    .sts_o  (aln_sts)
  );

  gcbp_xpose_buf u_xpose_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (buf_ctl),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data)
  );

endmodule

`default_nettype wire

[hdl/gcbp_aligner.sv]
// Bit aligner: shared shifter with spill carry and word count.
`default_nettype none

module gcbp_aligner (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gcbp_pkg::aln_ctl_t ctl_i,
  output gcbp_pkg::aln_sts_t     sts_o
);

  logic [7:0]  carry_q, carry_d;
  logic [2:0]  count_q, count_d;
  logic [15:0] sh_word;
  logic [2:0]  limit;
  logic [2:0]  count_inc;

  // Shift the word into the high byte, the spill lands in the low byte
  assign sh_word   = {ctl_i.data, 8'h00} >> ctl_i.shift;
  assign limit     = ctl_i.dbl ? gcbp_pkg::LIMIT_DOUBLE : gcbp_pkg::LIMIT_SINGLE;
  assign count_inc = count_q + 3'd1;

  // Present the aligned word, the carry and whether a carry word follows
  always_comb begin
    sts_o.aligned = (ctl_i.shift == 3'd0) ? ctl_i.data : (carry_q | sh_word[15:8]);
    sts_o.carry   = carry_q;
    sts_o.due     = (ctl_i.shift != 3'd0) && (count_inc == limit);
  end

  // Advance the carry and the count
  always_comb begin
    carry_d = carry_q;
    count_d = count_q;
    if (ctl_i.clear || ctl_i.take_carry) begin
      carry_d = 8'h00;
      count_d = 3'd0;
    end else if (ctl_i.step && (ctl_i.shift != 3'd0)) begin
      carry_d = sh_word[7:0];
      count_d = count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= 8'h00;
      count_q <= 3'd0;
    end else begin
      carry_q <= carry_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

[hdl/gcbp_xpose_buf.sv]
// Transpose buffer: merges glyph columns as bit columns, one read port.
`default_nettype none

module gcbp_xpose_buf (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire gcbp_pkg::buf_ctl_t                 ctl_i,
  input  wire logic [gcbp_pkg::BUF_IDX_W-1:0]     rd_idx_i,
  output logic      [7:0]                         rd_data_o
);

  logic [7:0] buf_q [gcbp_pkg::BUF_BYTES];
  logic [gcbp_pkg::BUF_BYTES-1:0] hit_s;
  logic [gcbp_pkg::BUF_BYTES-1:0] hit_d;
  logic [7:0] mask_s;
  logic [7:0] mask_d;

  // Bit masks for the current column phase
  assign mask_s = 8'h01 << (3'd7 - ctl_i.phase);
  assign mask_d = 8'h03 << (3'd6 - {ctl_i.phase[2:1], 1'b0});

  // Font bit that lands in each entry, single and double size
  for (genvar e = 0; e < gcbp_pkg::BUF_BYTES; e++) begin : g_hit
    localparam int unsigned C = (e >> 1) & 7;
    if (e < 8) begin : g_s_hi
      assign hit_s[e] = ctl_i.hi[7-e];
    end else if (e < 16) begin : g_s_lo
      assign hit_s[e] = ctl_i.lo[15-e];
    end else begin : g_s_none
      assign hit_s[e] = 1'b0;
    end
    if (e < 16) begin : g_d_hi
      assign hit_d[e] = ctl_i.hi[7-C];
    end else begin : g_d_lo
      assign hit_d[e] = ctl_i.lo[7-C];
    end
  end

  // Clear or merge every entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < gcbp_pkg::BUF_BYTES; e++) begin
        buf_q[e] <= 8'h00;
      end
    end else begin
      for (int e = 0; e < gcbp_pkg::BUF_BYTES; e++) begin
        if (ctl_i.clear) begin
          buf_q[e] <= 8'h00;
        end else if (ctl_i.merge) begin
          if (ctl_i.dbl && hit_d[e]) begin
            buf_q[e] <= buf_q[e] | mask_d;
          end else if (!ctl_i.dbl && hit_s[e]) begin
            buf_q[e] <= buf_q[e] | mask_s;
          end
        end
      end
    end
  end

  assign rd_data_o = buf_q[rd_idx_i];

endmodule

`default_nettype wire

[hdl/gcbp_ctrl.sv]
// Sequencer: configuration registers, command decode, word steps and output register.
`default_nettype none

module gcbp_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [1:0]                     cfg_index_i,
  input  wire logic [7:0]                     cfg_data_i,
  input  wire logic                           in_valid_i,
  input  wire gcbp_pkg::in_word_t             in_data_i,
  output logic                                in_stall_o,
  input  wire logic                           out_stall_i,
  output logic                                out_valid_o,
  output gcbp_pkg::out_word_t                 out_data_o,
  output gcbp_pkg::aln_ctl_t                  aln_ctl_o,
  input  wire gcbp_pkg::aln_sts_t             aln_sts_i,
  output gcbp_pkg::buf_ctl_t                  buf_ctl_o,
  output logic [gcbp_pkg::BUF_IDX_W-1:0]      rd_idx_o,
  input  wire logic [7:0]                     rd_data_i
);

  gcbp_pkg::state_e state_q, state_d;

  logic       dir_y_q, dbl_q;
  logic [2:0] sph_q;
  logic [2:0] phase_q;
  logic [2:0] step_q;
  logic [gcbp_pkg::BUF_IDX_W-1:0] idx_q;
  logic       flush_q;
  logic [7:0] b1_q, b2_q;

  logic                out_valid_q;
  gcbp_pkg::out_word_t out_q;
  gcbp_pkg::out_word_t word;
  logic                emit;

  logic       in_acc;
  logic       out_ready;
  logic       last_step;
  logic [2:0] phase_col;
  logic [gcbp_pkg::BUF_IDX_W-1:0] top_idx;
  logic       sel_second;
  logic [7:0] byte_sel;
  logic [7:0] y_src;

  assign in_stall_o = (state_q != gcbp_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == gcbp_pkg::ST_IDLE);
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign last_step  = dbl_q ? (step_q == 3'd7) : (step_q == 3'd1);
  assign phase_col  = dbl_q ? ({phase_q[2:1], 1'b0} + 3'd2) : (phase_q + 3'd1);
  assign top_idx    = dbl_q ? gcbp_pkg::TOP_DOUBLE : gcbp_pkg::TOP_SINGLE;

  // Pick the Y source word: each font byte, or its widened halves repeated
  assign sel_second = dbl_q ? step_q[1] : step_q[0];
  assign byte_sel   = sel_second ? b2_q : b1_q;
  assign y_src      = !dbl_q ? byte_sel
                    : (step_q[0] ? gcbp_pkg::widen_nibble(byte_sel[3:0])
                                 : gcbp_pkg::widen_nibble(byte_sel[7:4]));

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_y_q <= 1'b1;
      dbl_q   <= 1'b0;
      sph_q   <= 3'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gcbp_pkg::REG_DIRECTION_Y: dir_y_q <= cfg_data_i[0];
        gcbp_pkg::REG_DOUBLE_SIZE: dbl_q   <= cfg_data_i[0];
        gcbp_pkg::REG_START_PHASE: sph_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gcbp_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.cmd)
            gcbp_pkg::CMD_COLUMN: begin
              if (dir_y_q) begin
                state_d = gcbp_pkg::ST_Y_BYTE;
              end else if (phase_col == 3'd0) begin
                state_d = gcbp_pkg::ST_X_SEND;
              end
            end
            gcbp_pkg::CMD_END: begin
              if (!dir_y_q && (phase_q != 3'd0)) begin
                state_d = gcbp_pkg::ST_X_SEND;
              end
            end
            default: ;
          endcase
        end
      end
      gcbp_pkg::ST_Y_BYTE: begin
        if (out_ready) begin
          if (aln_sts_i.due) begin
            state_d = gcbp_pkg::ST_Y_CARRY;
          end else if (last_step) begin
            state_d = gcbp_pkg::ST_IDLE;
          end
        end
      end
      gcbp_pkg::ST_Y_CARRY: begin
        if (out_ready) begin
          state_d = last_step ? gcbp_pkg::ST_IDLE : gcbp_pkg::ST_Y_BYTE;
        end
      end
      gcbp_pkg::ST_X_SEND: begin
        if (out_ready && (idx_q == gcbp_pkg::BUF_IDX_W'(1))) begin
          state_d = gcbp_pkg::ST_IDLE;
        end
      end
      default: state_d = gcbp_pkg::ST_IDLE;
    endcase
  end

  // Outputs: words to emit and controls for the aligner and the buffer
  always_comb begin
    emit                 = 1'b0;
    word                 = '0;
    aln_ctl_o.clear      = 1'b0;
    aln_ctl_o.step       = 1'b0;
    aln_ctl_o.take_carry = 1'b0;
    aln_ctl_o.shift      = sph_q;
    aln_ctl_o.dbl        = dbl_q;
    aln_ctl_o.data       = y_src;
    buf_ctl_o.clear      = 1'b0;
    buf_ctl_o.merge      = 1'b0;
    buf_ctl_o.dbl        = dbl_q;
    buf_ctl_o.phase      = phase_q;
    buf_ctl_o.lo         = in_data_i.first_byte;
    buf_ctl_o.hi         = in_data_i.second_byte;
    unique case (state_q)
      gcbp_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.cmd)
            gcbp_pkg::CMD_START: begin
              aln_ctl_o.clear = 1'b1;
              buf_ctl_o.clear = 1'b1;
            end
            gcbp_pkg::CMD_COLUMN: begin
              buf_ctl_o.merge = !dir_y_q;
            end
            default: ;
          endcase
        end
      end
      gcbp_pkg::ST_Y_BYTE: begin
        if (out_ready) begin
          emit           = 1'b1;
          word.data_byte = aln_sts_i.aligned;
          word.last      = last_step && !aln_sts_i.due;
          aln_ctl_o.step = 1'b1;
        end
      end
      gcbp_pkg::ST_Y_CARRY: begin
        if (out_ready) begin
          emit                 = 1'b1;
          word.data_byte       = aln_sts_i.carry;
          word.last            = last_step;
          aln_ctl_o.take_carry = 1'b1;
        end
      end
      gcbp_pkg::ST_X_SEND: begin
        if (out_ready) begin
          emit              = 1'b1;
          word.data_byte    = rd_data_i;
          word.last         = (idx_q == gcbp_pkg::BUF_IDX_W'(1));
          word.column_flush = flush_q;
          buf_ctl_o.clear   = word.last && flush_q;
        end
      end
      default: ;
    endcase
  end

  assign rd_idx_o = idx_q;

  // Hold the state and the column phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gcbp_pkg::ST_IDLE;
      phase_q <= 3'd0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        case (in_data_i.cmd)
          gcbp_pkg::CMD_START:  phase_q <= dbl_q ? {sph_q[2:1], 1'b0} : sph_q;
          gcbp_pkg::CMD_COLUMN: if (!dir_y_q) phase_q <= phase_col;
          default: ;
        endcase
      end
    end
  end

  // Latch the item and advance step and index counters
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b1_q    <= in_data_i.first_byte;
      b2_q    <= in_data_i.second_byte;
      step_q  <= 3'd0;
      idx_q   <= top_idx;
      flush_q <= (in_data_i.cmd == gcbp_pkg::CMD_COLUMN);
    end else if (out_ready) begin
      case (state_q)
        gcbp_pkg::ST_Y_BYTE:  if (!aln_sts_i.due) step_q <= step_q + 3'd1;
        gcbp_pkg::ST_Y_CARRY: step_q <= step_q + 3'd1;
        gcbp_pkg::ST_X_SEND:  idx_q <= idx_q - gcbp_pkg::BUF_IDX_W'(1);
        default: ;
      endcase
    end
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[hdl/gcbp_checker.sv]
// Port checker for the glyph column to panel byte packer, bound to the top level.
`default_nettype none

module gcbp_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire gcbp_pkg::out_word_t out_data_o
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  // A word that is not the last one keeps the input stalled
  a_busy_until_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("input taken while an item still has bytes to send");

  // Flush words follow back to back while the output drains
  a_flush_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.column_flush && !out_data_o.last
    |=> out_valid_o && out_data_o.column_flush)
    else $error("column flush run broken");

  // Input stall only rises after an item was offered
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("input stalled without an item taken");

endmodule

bind glyph_column_to_panel_byte_packer gcbp_checker u_checker (.*);

`default_nettype wire

[tb/tb_packer_sb_pkg.sv]
// Scoreboard class of the glyph column to panel byte packer testbench.
package tb_packer_sb_pkg;

  import gcbp_pkg::*;

  // Command code that the block ignores, and a register index with no register
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  class panel_byte_predictor;
    // Own copy of the block state and settings
    logic [7:0] xbuf [BUF_BYTES];
    logic [2:0] col_phase;
    logic [7:0] carry;
    logic [2:0] carry_count;
    logic       dir_y;
    logic       dbl;
    logic [2:0] phase_reg;
    // Bytes of the word being worked out, and bytes still due at the output
    out_word_t  item_bytes[$];
    out_word_t  expected_bytes[$];
    int         errors;
    int         bytes_checked;
    int         words_noted;

    function new();
      foreach (xbuf[i]) xbuf[i] = 8'h00;
      col_phase     = '0;
      carry         = '0;
      carry_count   = '0;
      dir_y         = 1'b1;
      dbl           = 1'b0;
      phase_reg     = '0;
      errors        = 0;
      bytes_checked = 0;
      words_noted   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_DIRECTION_Y: dir_y = val[0];
        REG_DOUBLE_SIZE: dbl = val[0];
        REG_START_PHASE: phase_reg = val[2:0];
        default: ;
      endcase
    endfunction

    function void push_byte(logic [7:0] b, logic flush);
      out_word_t w;
      if (item_bytes.size() >= 31) return;
      w.data_byte    = b;
      w.last         = 1'b0;
      w.column_flush = flush;
      item_bytes.push_back(w);
    endfunction

    // Shift a byte by the start phase, carrying the spill into the next one
    function void align(logic [7:0] b);
      logic [2:0] lim;
      if (phase_reg == 3'd0) begin
        push_byte(b, 1'b0);
        return;
      end
      lim = dbl ? LIMIT_DOUBLE : LIMIT_SINGLE;
      carry = carry | (b >> phase_reg);
      push_byte(carry, 1'b0);
      carry = b << (4'd8 - phase_reg);
      carry_count = carry_count + 3'd1;
      if (carry_count == lim) begin
        push_byte(carry, 1'b0);
        carry       = '0;
        carry_count = '0;
      end
    endfunction

    // Double every bit, high nibble first, then align both halves
    function void widen_and_align(logic [7:0] b);
      logic [3:0] nib;
      for (int half = 0; half < 2; half++) begin
        nib = (half == 0) ? b[7:4] : b[3:0];
        align({nib[3], nib[3], nib[2], nib[2], nib[1], nib[1], nib[0], nib[0]});
      end
    endfunction

    // Send the buffer from the top index down to index 1
    function void send_xbuf(logic flush);
      int top;
      top = dbl ? 31 : 15;
      for (int i = top; i > 0; i--) push_byte(xbuf[i], flush);
    endfunction

    // Merge one glyph column into the transpose buffer
    function void merge_column(logic [7:0] lo, logic [7:0] hi);
      int         off;
      logic [7:0] m;
      if (!dbl) begin
        off = 7 - col_phase;
        for (int c = 0; c < 8; c++) begin
          if (hi[7-c]) xbuf[c][off] = 1'b1;
          if (lo[7-c]) xbuf[8+c][off] = 1'b1;
        end
        col_phase = col_phase + 3'd1;
      end else begin
        col_phase = col_phase & 3'b110;
        off = 6 - col_phase;
        m = 8'd3 << off;
        for (int c = 0; c < 8; c++) begin
          if (hi[7-c]) begin
            xbuf[2*c]   |= m;
            xbuf[2*c+1] |= m;
          end
          if (lo[7-c]) begin
            xbuf[2*c+16] |= m;
            xbuf[2*c+17] |= m;
          end
        end
        col_phase = col_phase + 3'd2;
      end
      if (col_phase == 3'd0) begin
        send_xbuf(1'b1);
        foreach (xbuf[i]) xbuf[i] = 8'h00;
      end
    endfunction

    // Work out the bytes that an accepted input word causes
    function void note_word(in_word_t w);
      item_bytes.delete();
      words_noted++;
      case (w.cmd)
        CMD_START: begin
          carry       = '0;
          carry_count = '0;
          foreach (xbuf[i]) xbuf[i] = 8'h00;
          col_phase = dbl ? (phase_reg & 3'b110) : phase_reg;
        end
        CMD_COLUMN: begin
          if (dir_y && dbl) begin
            for (int r = 0; r < 2; r++) begin
              widen_and_align(w.first_byte);
              widen_and_align(w.second_byte);
            end
          end else if (dir_y) begin
            align(w.first_byte);
            align(w.second_byte);
          end else begin
            merge_column(w.first_byte, w.second_byte);
          end
        end
        CMD_END: begin
          if (!dir_y && col_phase != 3'd0) send_xbuf(1'b0);
        end
        default: ;
      endcase
      if (item_bytes.size() > 0) item_bytes[item_bytes.size()-1].last = 1'b1;
      foreach (item_bytes[i]) expected_bytes.push_back(item_bytes[i]);
    endfunction

    // Compare an accepted output word with the oldest expected one
    function void check_byte(out_word_t got);
      out_word_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output word, data_byte %02h", got.data_byte);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte expected %02h got %02h", want.data_byte, got.data_byte);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0b got %0b", want.last, got.last);
        errors++;
      end
      if (got.column_flush !== want.column_flush) begin
        $error("column_flush expected %0b got %0b", want.column_flush, got.column_flush);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    // Report and drop expected words that never arrived
    function void drop_leftover();
      if (expected_bytes.size() != 0) begin
        $error("%0d expected output words never arrived", expected_bytes.size());
        errors++;
        expected_bytes.delete();
      end
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
// Top level of the glyph column to panel byte packer testbench.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import gcbp_pkg::*;
  import tb_packer_sb_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 40;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 600;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_WORDS  = 24;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_data;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;

  panel_byte_predictor packer_model = new();
  in_word_t            word_plan[$];
  int                  hold_req = 0;
  int                  phases_run = 0;
  int                  cycle_count = 0;

  glyph_column_to_panel_byte_packer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #4 clk = ~clk;

  // Watch all three channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) packer_model.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) packer_model.note_word(in_data);
      if (out_valid && !out_stall) packer_model.check_byte(out_data);
    end
  end

  // Abandon a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          hold_left = 0;
  int          hold_seen = 0;
  int          beat = 0;

  always @(negedge clk) begin : receiver_pattern
    logic stall_now;
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_now = 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 120);
      end
      stall_left--;
      beat++;
      case (stall_mode)
        STALL_LIGHT:    stall_now = ($urandom_range(0, 99) < 30);
        STALL_PERIODIC: stall_now = ((beat % 5) < 2);
        STALL_HEAVY:    stall_now = ($urandom_range(0, 99) < 70);
        default:        stall_now = 1'b0;
      endcase
    end
    out_stall <= stall_now;
  end

  // Write one register and wait for the handshake
  task automatic put_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write every register, spare bits random, plus a write to the empty index
  task automatic write_settings(logic d, logic s, logic [2:0] p);
    logic [7:0] v;
    v = 8'($urandom);
    v[0] = d;
    put_reg(REG_DIRECTION_Y, v);
    v = 8'($urandom);
    v[0] = s;
    put_reg(REG_DOUBLE_SIZE, v);
    v = 8'($urandom);
    v[2:0] = p;
    put_reg(REG_START_PHASE, v);
    put_reg(REG_UNUSED, 8'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void plan_word(logic [1:0] c, logic [7:0] a, logic [7:0] b);
    in_word_t w;
    w.cmd         = c;
    w.first_byte  = a;
    w.second_byte = b;
    word_plan.push_back(w);
  endfunction

  // Mostly well-formed start, columns, end runs; the rest loose commands
  task automatic plan_random(int count);
    int         made;
    logic [1:0] c;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 9) != 0) begin
          plan_word(CMD_START, 8'($urandom), 8'($urandom));
          made++;
        end
        repeat ($urandom_range(1, 18)) begin
          plan_word(CMD_COLUMN, 8'($urandom), 8'($urandom));
          made++;
        end
        if ($urandom_range(0, 4) != 0) begin
          plan_word(CMD_END, 8'($urandom), 8'($urandom));
          made++;
        end
      end else begin
        c = 2'($urandom_range(0, 3));
        plan_word(c, 8'($urandom), 8'($urandom));
        if (c != CMD_UNUSED) made++;
      end
    end
  endtask

  // Offer the planned words in bursts, or back to back when steady
  task automatic send_plan(bit steady);
    int burst_left;
    burst_left = $urandom_range(1, 12);
    foreach (word_plan[i]) begin
      @(negedge clk);
      in_valid <= 1'b1;
      in_data  <= word_plan[i];
      do @(posedge clk); while (in_stall);
      if (!steady) begin
        burst_left--;
        if (burst_left == 0) begin
          repeat ($urandom_range(1, 6)) begin
            @(negedge clk);
            in_valid <= 1'b0;
          end
          burst_left = $urandom_range(1, 12);
        end
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    word_plan.delete();
  endtask

  // Wait for every expected word, then let the block settle
  task automatic wait_drained();
    int waited;
    waited = 0;
    while (packer_model.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    packer_model.drop_leftover();
    repeat (DRAIN_CYCLES) @(posedge clk);
    phases_run++;
  endtask

  initial begin : stimulus
    logic       d;
    logic       s;
    logic [2:0] p;
    bit         steady;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: Y mode, no shift, plus an ignored command
    plan_word(CMD_START, 8'h00, 8'h00);
    plan_word(CMD_COLUMN, 8'hFF, 8'h00);
    plan_word(CMD_COLUMN, 8'h00, 8'hFF);
    plan_word(CMD_UNUSED, 8'hA5, 8'h5A);
    plan_word(CMD_END, 8'hFF, 8'hFF);
    send_plan(1'b0);
    wait_drained();

    // Largest shift, single size: carry word after every column
    write_settings(1'b1, 1'b0, 3'd7);
    plan_word(CMD_START, 8'hFF, 8'hFF);
    plan_word(CMD_COLUMN, 8'hFF, 8'hFF);
    plan_word(CMD_COLUMN, 8'h81, 8'h7E);
    plan_word(CMD_COLUMN, 8'h01, 8'h80);
    plan_word(CMD_END, 8'h00, 8'h00);
    send_plan(1'b0);
    wait_drained();

    // Double size in Y with an odd shift
    write_settings(1'b1, 1'b1, 3'd3);
    plan_word(CMD_START, 8'h00, 8'h00);
    plan_word(CMD_COLUMN, 8'hA5, 8'h5A);
    plan_word(CMD_COLUMN, 8'hFF, 8'h01);
    plan_word(CMD_END, 8'h00, 8'h00);
    send_plan(1'b0);
    wait_drained();

    // X mode single size: byte column completes, then a partial flush on end
    write_settings(1'b0, 1'b0, 3'd5);
    plan_word(CMD_START, 8'h00, 8'h00);
    plan_word(CMD_COLUMN, 8'hFF, 8'h00);
    plan_word(CMD_COLUMN, 8'h00, 8'hFF);
    plan_word(CMD_COLUMN, 8'h81, 8'h42);
    plan_word(CMD_COLUMN, 8'hFF, 8'hFF);
    plan_word(CMD_END, 8'h00, 8'h00);
    send_plan(1'b0);
    wait_drained();

    // X mode double size with an odd phase, whose low bit is dropped
    write_settings(1'b0, 1'b1, 3'd7);
    plan_word(CMD_START, 8'h00, 8'h00);
    plan_word(CMD_COLUMN, 8'h81, 8'h18);
    plan_word(CMD_COLUMN, 8'hC3, 8'h3C);
    plan_word(CMD_END, 8'h00, 8'h00);
    send_plan(1'b0);
    wait_drained();

    // Random phases under changing settings
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      d = 1'($urandom_range(0, 1));
      s = 1'($urandom_range(0, 1));
      p = 3'($urandom_range(0, 7));
      steady = (ph == 4);
      case (ph)
        0: p = 3'd7;
        1: p = 3'd0;
        2: begin
          d = 1'b1;
          s = 1'b1;
          steady = 1'b1;
        end
        3: begin
          d = 1'b0;
          s = 1'b1;
        end
        default: ;
      endcase
      write_settings(d, s, p);
      plan_random(PHASE_WORDS);
      // Hold the output off while words keep coming so the block backs up
      if (ph == 2) hold_req++;
      send_plan(steady);
      wait_drained();
    end

    $display("Summary: %0d input words taken, %0d output bytes checked",
             packer_model.words_noted, packer_model.bytes_checked);
    $display("Covered %0d setting phases: both modes, both sizes, shifts 0 to 7, long hold-off",
             phases_run);
    if (packer_model.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
